@@ hdl/utt_pkg.sv @@
package utt_pkg;

    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;
    localparam int HELD_W = 11;
    localparam int CP_W   = 22;
    localparam int MAX_BYTES = 4;
    localparam int CNT_W  = 3;
    localparam int LEFT_W = 2;

    localparam logic [CP_W-1:0]   CP_MAX       = 22'h10FFFF;
    localparam logic [CP_W-1:0]   CP_1B_MAX    = 22'h00007F;
    localparam logic [CP_W-1:0]   CP_2B_MAX    = 22'h0007FF;
    localparam logic [CP_W-1:0]   CP_3B_MAX    = 22'h00FFFF;
    // 0x10000 - 0xDC00, folded so a pair needs a single add
    localparam logic [CP_W-1:0]   CP_PAIR_BIAS = 22'h002400;
    localparam logic [4:0]        SURR_PREFIX  = 5'b11011;

    localparam logic [BYTE_W-1:0] LEAD2 = 8'b11000000;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'b11100000;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'b11110000;
    localparam logic [BYTE_W-1:0] CONT  = 8'b10000000;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    } utf8_seq_t;

    typedef struct packed {
        utf8_seq_t         seq;
        logic              pend;
        logic [HELD_W-1:0] held;
    } enc_t;

endpackage

@@ hdl/utt_encode.sv @@
module utt_encode (
    input  logic [utt_pkg::UNIT_W-1:0] unit,
    input  logic                       unit_last,
    input  logic                       pending,
    input  logic [utt_pkg::HELD_W-1:0] held,
    output utt_pkg::enc_t              enc
);
    import utt_pkg::*;

    logic [CP_W-1:0] cp;
    logic            is_surr;

    function automatic utf8_seq_t encode_cp(input logic [CP_W-1:0] c);
        utf8_seq_t s;
        s = '0;
        priority if (c == '0 || c > CP_MAX)
        begin
            s.count = CNT_W'(1);
        end
        else if (c <= CP_1B_MAX)
        begin
            s.count    = CNT_W'(1);
            s.bytes[0] = {1'b0, c[6:0]};
        end
        else if (c <= CP_2B_MAX)
        begin
            s.count    = CNT_W'(2);
            s.bytes[0] = LEAD2 | {3'b000, c[10:6]};
            s.bytes[1] = CONT | {2'b00, c[5:0]};
        end
        else if (c <= CP_3B_MAX)
        begin
            s.count    = CNT_W'(3);
            s.bytes[0] = LEAD3 | {4'b0000, c[15:12]};
            s.bytes[1] = CONT | {2'b00, c[11:6]};
            s.bytes[2] = CONT | {2'b00, c[5:0]};
        end
        else
        begin
            s.count    = CNT_W'(4);
            s.bytes[0] = LEAD4 | {5'b00000, c[20:18]};
            s.bytes[1] = CONT | {2'b00, c[17:12]};
            s.bytes[2] = CONT | {2'b00, c[11:6]};
            s.bytes[3] = CONT | {2'b00, c[5:0]};
        end
        return s;
    endfunction

    assign is_surr = (unit[UNIT_W-1:UNIT_W-5] == SURR_PREFIX);

    // the second unit is never checked: any unit completes a held one
    assign cp = pending ? ({1'b0, held, 10'b0} + {6'b0, unit} + CP_PAIR_BIAS)
                        : {6'b0, unit};

    always_comb
    begin
        enc      = '0;
        enc.pend = 1'b0;
        enc.held = '0;
        if (pending)
        begin
            enc.seq = encode_cp(cp);
        end
        else if (is_surr)
        begin
            if (!unit_last)
            begin
                enc.pend = 1'b1;
                enc.held = unit[HELD_W-1:0];
            end
            else
            begin
                // unpaired at string end: single zero byte
                enc.seq.count = CNT_W'(1);
            end
        end
        else
        begin
            enc.seq = encode_cp(cp);
        end
    end

endmodule

@@ hdl/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder. One 16-bit code unit per request on the s_axis
// side, one UTF-8 byte per request on the m_axis side, lead byte first. A unit
// waits in the input register, is encoded into the result buffer once that is
// free, and its 1 to 4 bytes then leave one per cycle while m_axis_tready is
// high, so throughput is set by the byte-wide output channel; a first
// surrogate unit produces nothing. The next unit is taken while the previous
// one's bytes drain. tuser flags the last byte of each unit, tlast the last
// byte of the string. A zero code point, a pair above 10FFFF, and a lone
// surrogate at string end each give one zero byte; no terminator is sent.
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
    input  logic        s_axis_tlast,  // unit_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tuser,  // [0] char_last
    output logic        m_axis_tlast   // string_end
);
    import utt_pkg::*;

    logic                             in_valid_reg;
    logic [UNIT_W-1:0]                in_unit_reg;
    logic                             in_last_reg;
    logic                             pend_reg;
    logic [HELD_W-1:0]                held_reg;
    logic                             res_valid_reg;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] res_bytes_reg;
    logic [LEFT_W-1:0]                res_left_reg;
    logic                             res_last_reg;

    enc_t enc;
    logic in_take;
    logic out_take;
    logic res_done;
    logic res_free;
    logic advance;
    logic has_bytes;

    utt_encode u_encode (
        .unit      (in_unit_reg),
        .unit_last (in_last_reg),
        .pending   (pend_reg),
        .held      (held_reg),
        .enc       (enc)
    );

    assign has_bytes = (enc.seq.count != '0);
    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign res_done  = out_take && (res_left_reg == '0);
    assign res_free  = !res_valid_reg || res_done;
    assign advance   = in_valid_reg && (!has_bytes || res_free);

    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = res_bytes_reg[0];
    assign m_axis_tuser  = (res_left_reg == '0);
    assign m_axis_tlast  = (res_left_reg == '0) && res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_unit_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            held_reg <= '0;
        end
        else if (advance)
        begin
            pend_reg <= enc.pend;
            held_reg <= enc.held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_left_reg  <= '0;
        end
        else if (out_take && !res_done)
        begin
            res_left_reg <= res_left_reg - LEFT_W'(1);
        end
        else if (advance && has_bytes)
        begin
            res_valid_reg <= 1'b1;
            res_left_reg  <= LEFT_W'(enc.seq.count - CNT_W'(1));
        end
        else if (res_done)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && !res_done)
        begin
            res_bytes_reg <= {{BYTE_W{1'b0}}, res_bytes_reg[MAX_BYTES-1:1]};
        end
        else if (advance && has_bytes)
        begin
            res_bytes_reg <= enc.seq.bytes;
            res_last_reg  <= in_last_reg;
        end
    end

    a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> held_reg == '0)
        else $error("held offset nonzero with no pair pending");

    a_left_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_left_reg != '0 |-> res_valid_reg)
        else $error("bytes left in an empty result buffer");

    a_tlast_tuser: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("string end not on a unit's last byte");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && res_valid_reg)
        else $error("input stalled with a free stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && res_left_reg != '0 |=> res_valid_reg)
        else $error("result dropped before its last byte");

endmodule

@@ bench/utf16_to_utf8_transcoder_test.sv @@
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_test;

    import utt_pkg::UNIT_W;
    import utt_pkg::BYTE_W;
    import utt_pkg::HELD_W;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [UNIT_W-1:0] unit;
        logic              last;
        int                idle_pct;
        int                stall_pct;
        logic              drain;
    } unit_req_t;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              char_last;
        logic              string_end;
    } utf8_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [UNIT_W-1:0] s_axis_tdata = '0;  // [15:0] code_unit
    logic              s_axis_tlast = 1'b0;  // unit_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;  // [7:0] out_byte
    logic              m_axis_tuser;  // [0] char_last
    logic              m_axis_tlast;  // string_end

    unit_req_t  unit_reqs[$];
    utf8_byte_t utf8_expected[$];

    // predictor state: first half of a surrogate pair
    logic              pair_held = 1'b0;
    logic [HELD_W-1:0] held_offset = '0;

    int cur_idle = 0;
    int cur_stall = 0;
    logic drain_next = 1'b0;
    int units_queued = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet = 0;

    utf16_to_utf8_transcoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected UTF-8 bytes for one accepted code unit.
    function automatic void predict_utf8(input logic [UNIT_W-1:0] unit, input logic last);
        logic [31:0]       cp;
        logic [BYTE_W-1:0] b [4];
        int                n;
        utf8_byte_t        e;
        if (pair_held)
        begin
            cp = {21'd0, held_offset} * 32'h400 + {16'd0, unit} - 32'hDC00 + 32'h10000;
            pair_held = 1'b0;
            held_offset = '0;
        end
        else if (unit >= 16'hD800 && unit <= 16'hDFFF)
        begin
            if (!last)
            begin
                pair_held = 1'b1;
                held_offset = unit[HELD_W-1:0];
                return;
            end
            cp = 32'd0;  // lone surrogate at string end: one zero byte
        end
        else
            cp = {16'd0, unit};

        if (cp == 32'd0 || cp > 32'h10FFFF)
        begin
            b[0] = 8'h00;
            n = 1;
        end
        else if (cp <= 32'h7F)
        begin
            b[0] = cp[7:0];
            n = 1;
        end
        else if (cp <= 32'h7FF)
        begin
            b[0] = 8'hC0 | {3'b000, cp[10:6]};
            b[1] = 8'h80 | {2'b00, cp[5:0]};
            n = 2;
        end
        else if (cp <= 32'hFFFF)
        begin
            b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            b[1] = 8'h80 | {2'b00, cp[11:6]};
            b[2] = 8'h80 | {2'b00, cp[5:0]};
            n = 3;
        end
        else
        begin
            b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            b[1] = 8'h80 | {2'b00, cp[17:12]};
            b[2] = 8'h80 | {2'b00, cp[11:6]};
            b[3] = 8'h80 | {2'b00, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            e.out_byte = b[k];
            e.char_last = (k == n - 1);
            e.string_end = (k == n - 1) && last;
            utf8_expected = {utf8_expected, e};
        end
    endfunction

    task automatic add_unit(input logic [UNIT_W-1:0] unit, input logic last);
        unit_req_t r;
        r.unit = unit;
        r.last = last;
        r.idle_pct = cur_idle;
        r.stall_pct = cur_stall;
        r.drain = drain_next;
        drain_next = 1'b0;
        unit_reqs = {unit_reqs, r};
        units_queued++;
    endtask

    // Mostly well-formed text; about a sixth of the units are arbitrary or stray surrogates.
    task automatic add_string(input int len);
        int                k;
        int                pick;
        logic [UNIT_W-1:0] u;
        k = 0;
        while (k < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 80 && k + 1 < len)
            begin
                add_unit(UNIT_W'(16'hD800 + $urandom_range(0, 16'h3FF)), 1'b0);
                add_unit(UNIT_W'(16'hDC00 + $urandom_range(0, 16'h3FF)), k + 2 == len);
                k += 2;
            end
            else
            begin
                if (pick < 25)
                    u = UNIT_W'($urandom_range(0, 16'h7F));
                else if (pick < 40)
                    u = UNIT_W'($urandom_range(16'h80, 16'h7FF));
                else if (pick < 80)
                    u = $urandom_range(0, 1) ? UNIT_W'($urandom_range(16'h800, 16'hD7FF))
                                             : UNIT_W'($urandom_range(16'hE000, 16'hFFFF));
                else if (pick < 90)
                    u = UNIT_W'($urandom_range(16'hD800, 16'hDFFF));
                else
                    u = UNIT_W'($urandom());
                add_unit(u, k + 1 == len);
                k++;
            end
        end
    endtask

    task automatic add_phase(input int idle_pct, input int stall, input int count);
        int stop;
        cur_idle = idle_pct;
        cur_stall = stall;
        drain_next = 1'b1;
        stop = units_queued + count;
        while (units_queued < stop)
        begin
            if ($urandom_range(0, 19) == 0)
                drain_next = 1'b1;
            add_string($urandom_range(1, 12));
        end
    endtask

    // Sender: presents queued units, predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        unit_req_t nxt;
        logic      send;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_utf8(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                send = 1'b0;
                if (unit_reqs.size() != 0)
                begin
                    nxt = unit_reqs[0];
                    if (nxt.drain && (utf8_expected.size() != 0 || s_axis_tvalid))
                        send = 1'b0;
                    else
                        send = ($urandom_range(0, 99) >= nxt.idle_pct);
                end
                if (send)
                begin
                    void'(unit_reqs.pop_front());
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.unit;
                    s_axis_tlast <= nxt.last;
                    stall_pct <= nxt.stall_pct;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure and byte checks.
    always @(posedge clk or negedge rst_n)
    begin
        utf8_byte_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (utf8_expected.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, actual %h user %b last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    e = utf8_expected.pop_front();
                    if (m_axis_tdata !== e.out_byte)
                    begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, e.out_byte, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== e.char_last)
                    begin
                        $display("%0t: char_last mismatch: expected %b, actual %b",
                                 $time, e.char_last, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== e.string_end)
                    begin
                        $display("%0t: string_end mismatch: expected %b, actual %b",
                                 $time, e.string_end, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("** utf16_to_utf8_transcoder: FAILED **");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        // directed: range edges, pairs, broken and out-of-range pairs, string ends
        add_unit(16'h0000, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hD7FF, 1'b0);
        add_unit(16'hE000, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        add_unit(16'hD800, 1'b0);
        add_unit(16'hDC00, 1'b0);
        add_unit(16'hDBFF, 1'b0);
        add_unit(16'hDFFF, 1'b0);
        add_unit(16'hDFFF, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        add_unit(16'hD800, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'hDC00, 1'b1);
        add_unit(16'hD83D, 1'b0);
        add_unit(16'hDE00, 1'b1);
        add_unit(16'h0000, 1'b1);
        add_unit(16'hDBFF, 1'b0);
        add_unit(16'hD800, 1'b0);
        add_unit(16'hFFFF, 1'b1);

        add_phase(0, 0, 90);
        add_phase(73, 0, 90);
        add_phase(0, 73, 90);
        add_phase(19, 19, 90);
        add_phase(0, 0, 60);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (unit_reqs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (utf8_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("** utf16_to_utf8_transcoder: PASSED **");
        else
            $display("** utf16_to_utf8_transcoder: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/utt_pkg.sv
hdl/utt_encode.sv
hdl/utf16_to_utf8_transcoder.sv
bench/utf16_to_utf8_transcoder_test.sv
